@@ design/rnh_pkg.sv @@
// Shared types and constants for the ray / ellipsoid nearest-hit block.
// No dependencies; imported by every module of the block.
package rnh_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int CNT_W      = $clog2(MAX_POINTS);
    localparam int ADDR_W     = 5;

    // register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_ORIGIN_X = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [2:0] REG_DIR_X    = 3'd3;
    localparam logic [2:0] REG_DIR_Y    = 3'd4;
    localparam logic [2:0] REG_DIR_Z    = 3'd5;

    localparam logic [31:0] DIR_Z_RESET = 32'h0001_0000;
    localparam logic [63:0] ONE_Q32     = 64'h0000_0001_0000_0000;
    localparam logic [29:0] COORD_LIM   = 30'h3FFF_FFFF;
    localparam logic [31:0] DIST_MAX    = 32'hFFFF_FFFF;

    typedef struct packed {
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] center_z;
        logic [30:0]        radius_x;
        logic [30:0]        radius_y;
        logic [30:0]        radius_z;
        logic [9:0]         point_id;
        logic               last_in_set;
    } item_t;

    typedef struct packed {
        logic        item_hit;
        logic [31:0] item_dist;
        logic        nearest_hit;
        logic [31:0] nearest_dist;
        logic [9:0]  nearest_id;
        logic        set_done;
    } result_t;

    typedef struct packed {
        logic signed [31:0] ray_origin_x;
        logic signed [31:0] ray_origin_y;
        logic signed [31:0] ray_origin_z;
        logic signed [31:0] ray_dir_x;
        logic signed [31:0] ray_dir_y;
        logic signed [31:0] ray_dir_z;
    } ray_cfg_t;

    typedef struct packed {
        logic        hit;
        logic [31:0] t_dist;
    } core_res_t;

endpackage

@@ design/rnh_apb_regs.sv @@
// APB register file holding the ray origin and direction.
// Depends on rnh_pkg.
module rnh_apb_regs
    import rnh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output ray_cfg_t          cfg
);

    ray_cfg_t   cfg_reg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ray_origin_x <= '0;
            cfg_reg.ray_origin_y <= '0;
            cfg_reg.ray_origin_z <= '0;
            cfg_reg.ray_dir_x    <= '0;
            cfg_reg.ray_dir_y    <= '0;
            cfg_reg.ray_dir_z    <= DIR_Z_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_ORIGIN_X: cfg_reg.ray_origin_x <= pwdata;
                REG_ORIGIN_Y: cfg_reg.ray_origin_y <= pwdata;
                REG_ORIGIN_Z: cfg_reg.ray_origin_z <= pwdata;
                REG_DIR_X:    cfg_reg.ray_dir_x    <= pwdata;
                REG_DIR_Y:    cfg_reg.ray_dir_y    <= pwdata;
                REG_DIR_Z:    cfg_reg.ray_dir_z    <= pwdata;
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_ORIGIN_X: prdata = cfg_reg.ray_origin_x;
            REG_ORIGIN_Y: prdata = cfg_reg.ray_origin_y;
            REG_ORIGIN_Z: prdata = cfg_reg.ray_origin_z;
            REG_DIR_X:    prdata = cfg_reg.ray_dir_x;
            REG_DIR_Y:    prdata = cfg_reg.ray_dir_y;
            REG_DIR_Z:    prdata = cfg_reg.ray_dir_z;
            default:      prdata = '0;
        endcase
    end

endmodule

@@ design/rnh_div.sv @@
// Restoring divider, one quotient bit per cycle, 30 or 32 quotient bits.
// Flags saturation up front when the quotient would not fit. Depends on rnh_pkg.
module rnh_div
    import rnh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [79:0] num,
    input  logic [63:0] den,
    input  logic        wide,
    output logic        done,
    output logic [31:0] quot,
    output logic        sat
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic        sat_reg, sat_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [63:0] rem_reg, rem_next;
    logic [63:0] den_reg, den_next;
    logic [31:0] low_reg, low_next;
    logic [31:0] q_reg, q_next;
    logic [79:0] head;
    logic        head_sat;
    logic [63:0] r2;
    logic        ge;

    // quotient fits in n bits iff num >> n < den
    assign head     = wide ? (num >> 32) : (num >> 30);
    assign head_sat = head >= {16'd0, den};
    assign r2       = {rem_reg[62:0], low_reg[31]};
    assign ge       = r2 >= den_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        sat_next  = sat_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        low_next  = low_reg;
        q_next    = q_reg;
        if (start)
        begin
            sat_next = head_sat;
            rem_next = head[63:0];
            den_next = den;
            low_next = wide ? num[31:0] : {num[29:0], 2'b00};
            cnt_next = wide ? 6'd32 : 6'd30;
            q_next   = '0;
            busy_next = !head_sat;
            done_next = head_sat;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? (r2 - den_reg) : r2;
            q_next   = {q_reg[30:0], ge};
            low_next = {low_reg[30:0], 1'b0};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            sat_reg  <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
            low_reg  <= '0;
            q_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            sat_reg  <= sat_next;
            cnt_reg  <= cnt_next;
            rem_reg  <= rem_next;
            den_reg  <= den_next;
            low_reg  <= low_next;
            q_reg    <= q_next;
        end
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign sat  = sat_reg;

endmodule

@@ design/rnh_isqrt.sv @@
// Digit-by-digit integer square root of a 128-bit value, one root bit per cycle.
// Depends on rnh_pkg.
module rnh_isqrt
    import rnh_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [127:0] value,
    output logic         done,
    output logic [63:0]  root
);

    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic [6:0]   cnt_reg, cnt_next;
    logic [127:0] val_reg, val_next;
    logic [66:0]  rem_reg, rem_next;
    logic [63:0]  root_reg, root_next;
    logic [66:0]  r2;
    logic [66:0]  trial;
    logic         ge;

    assign r2    = {rem_reg[64:0], val_reg[127:126]};
    assign trial = {1'b0, root_reg, 2'b01};
    assign ge    = r2 >= trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        val_next  = val_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 7'd64;
            val_next  = value;
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? (r2 - trial) : r2;
            root_next = {root_reg[62:0], ge};
            val_next  = {val_reg[125:0], 2'b00};
            cnt_next  = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            val_reg  <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            val_reg  <= val_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

@@ design/rnh_core.sv @@
// Per-ellipsoid sequencer: axis scaling on the divider, quadratic terms on a
// shared 32x32 multiply-accumulate, root on the square-root unit.
// Depends on rnh_pkg, rnh_div, rnh_isqrt.
module rnh_core
    import rnh_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  item_t     item,
    input  ray_cfg_t  cfg,
    output logic      res_valid,
    input  logic      res_ready,
    output core_res_t res,
    output logic      busy
);

    typedef enum logic [3:0] {
        S_IDLE, S_DIV_GO, S_DIV_WAIT, S_MAC, S_SQRT_WAIT,
        S_ROOT1, S_ROOT1_WAIT, S_ROOT2, S_ROOT2_WAIT, S_DONE
    } state_t;

    state_t       state_reg, state_next;
    logic [2:0]   idx_reg, idx_next;
    logic [4:0]   step_reg, step_next;
    logic [127:0] acc_reg, acc_next;
    logic [61:0]  a_reg, a_next;
    logic [61:0]  ssum_reg, ssum_next;
    logic [63:0]  h_reg, h_next;
    logic [63:0]  sq_reg, sq_next;
    logic [29:0]  smag_reg [3];
    logic [29:0]  smag_next [3];
    logic [29:0]  dmag_reg [3];
    logic [29:0]  dmag_next [3];
    logic         sneg_reg [3];
    logic         sneg_next [3];
    logic         dneg_reg [3];
    logic         dneg_next [3];
    logic         hit_reg, hit_next;
    logic [31:0]  dist_reg, dist_next;

    logic [1:0]   axis;
    logic [31:0]  org, cen, dirv;
    logic [30:0]  rad;
    logic [32:0]  v33, mag33;
    logic [29:0]  q30;

    logic         div_start, div_wide, div_done, div_sat;
    logic [79:0]  div_num;
    logic [63:0]  div_den;
    logic [31:0]  div_quot, t_q;
    logic         sqrt_start, sqrt_done;
    logic [63:0]  sqrt_root;

    logic [31:0]  mx, my;
    logic [1:0]   sh;
    logic         sub, clr;
    logic [63:0]  prod;
    logic [127:0] ext, addend, acc_sum;
    logic [63:0]  h_abs, c_val, c_abs, n2;
    logic         c_pos;

    assign axis = idx_reg[2:1];

    always_comb
    begin
        case (axis)
            2'd0:
            begin
                org = cfg.ray_origin_x; cen = item.center_x;
                dirv = cfg.ray_dir_x;   rad = item.radius_x;
            end
            2'd1:
            begin
                org = cfg.ray_origin_y; cen = item.center_y;
                dirv = cfg.ray_dir_y;   rad = item.radius_y;
            end
            default:
            begin
                org = cfg.ray_origin_z; cen = item.center_z;
                dirv = cfg.ray_dir_z;   rad = item.radius_z;
            end
        endcase
    end

    // odd index scales the direction, even the origin offset
    assign v33   = idx_reg[0] ? {dirv[31], dirv} : ({org[31], org} - {cen[31], cen});
    assign mag33 = v33[32] ? (33'd0 - v33) : v33;
    assign q30   = div_sat ? COORD_LIM : div_quot[29:0];
    assign t_q   = div_sat ? DIST_MAX : div_quot;

    assign h_abs = h_reg[63] ? (64'd0 - h_reg) : h_reg;
    assign c_val = {2'b00, ssum_reg} - ONE_Q32;
    assign c_abs = c_val[63] ? (64'd0 - c_val) : c_val;
    assign c_pos = !c_val[63] && (c_val != 64'd0);
    assign n2    = h_reg[63] ? (sq_reg + h_abs)
                 : ((sq_reg > h_abs) ? (sq_reg - h_abs) : 64'd0);

    // MAC schedule: a, sum s^2, h, then D = h^2 - a*c from 32-bit partials
    always_comb
    begin
        mx = '0; my = '0; sh = 2'd0; sub = 1'b0; clr = 1'b0;
        case (step_reg)
            5'd0:  begin mx = {2'b00, dmag_reg[0]}; my = mx; clr = 1'b1; end
            5'd1:  begin mx = {2'b00, dmag_reg[1]}; my = mx; end
            5'd2:  begin mx = {2'b00, dmag_reg[2]}; my = mx; end
            5'd3:  begin mx = {2'b00, smag_reg[0]}; my = mx; clr = 1'b1; end
            5'd4:  begin mx = {2'b00, smag_reg[1]}; my = mx; end
            5'd5:  begin mx = {2'b00, smag_reg[2]}; my = mx; end
            5'd6:
            begin
                mx = {2'b00, dmag_reg[0]}; my = {2'b00, smag_reg[0]};
                sub = dneg_reg[0] ^ sneg_reg[0]; clr = 1'b1;
            end
            5'd7:
            begin
                mx = {2'b00, dmag_reg[1]}; my = {2'b00, smag_reg[1]};
                sub = dneg_reg[1] ^ sneg_reg[1];
            end
            5'd8:
            begin
                mx = {2'b00, dmag_reg[2]}; my = {2'b00, smag_reg[2]};
                sub = dneg_reg[2] ^ sneg_reg[2];
            end
            5'd9:  begin mx = h_abs[31:0];  my = h_abs[31:0];  clr = 1'b1; end
            5'd10: begin mx = h_abs[31:0];  my = h_abs[63:32]; sh = 2'd1; end
            5'd11: begin mx = h_abs[63:32]; my = h_abs[31:0];  sh = 2'd1; end
            5'd12: begin mx = h_abs[63:32]; my = h_abs[63:32]; sh = 2'd2; end
            5'd13: begin mx = a_reg[31:0]; my = c_abs[31:0]; sub = c_pos; end
            5'd14:
            begin
                mx = a_reg[31:0]; my = c_abs[63:32]; sh = 2'd1; sub = c_pos;
            end
            5'd15:
            begin
                mx = {2'b00, a_reg[61:32]}; my = c_abs[31:0]; sh = 2'd1; sub = c_pos;
            end
            5'd16:
            begin
                mx = {2'b00, a_reg[61:32]}; my = c_abs[63:32]; sh = 2'd2; sub = c_pos;
            end
            default: ;
        endcase
    end

    assign prod    = {32'd0, mx} * {32'd0, my};
    assign ext     = {64'd0, prod} << {sh, 5'd0};
    assign addend  = sub ? (128'd0 - ext) : ext;
    assign acc_sum = (clr ? 128'd0 : acc_reg) + addend;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        step_next  = step_reg;
        acc_next   = acc_reg;
        a_next     = a_reg;
        ssum_next  = ssum_reg;
        h_next     = h_reg;
        sq_next    = sq_reg;
        smag_next  = smag_reg;
        dmag_next  = dmag_reg;
        sneg_next  = sneg_reg;
        dneg_next  = dneg_reg;
        hit_next   = hit_reg;
        dist_next  = dist_reg;
        div_start  = 1'b0;
        div_wide   = 1'b0;
        div_num    = {31'd0, mag33, 16'd0};
        div_den    = {33'd0, rad};
        sqrt_start = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    hit_next  = 1'b0;
                    dist_next = '0;
                    idx_next  = '0;
                    if (item.radius_x == '0 || item.radius_y == '0 || item.radius_z == '0)
                        state_next = S_DONE;
                    else
                        state_next = S_DIV_GO;
                end
            end
            S_DIV_GO:
            begin
                div_start  = 1'b1;
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (div_done)
                begin
                    if (idx_reg[0])
                    begin
                        dmag_next[axis] = q30;
                        dneg_next[axis] = v33[32];
                    end
                    else
                    begin
                        smag_next[axis] = q30;
                        sneg_next[axis] = v33[32];
                    end
                    if (idx_reg == 3'd5)
                    begin
                        step_next  = '0;
                        state_next = S_MAC;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 3'd1;
                        state_next = S_DIV_GO;
                    end
                end
            end
            S_MAC:
            begin
                acc_next  = acc_sum;
                step_next = step_reg + 5'd1;
                if (step_reg == 5'd2)
                    a_next = acc_sum[61:0];
                if (step_reg == 5'd5)
                    ssum_next = acc_sum[61:0];
                if (step_reg == 5'd8)
                    h_next = acc_sum[63:0];
                if (step_reg == 5'd16)
                begin
                    // zero a or negative discriminant: no hit
                    if (acc_sum[127] || a_reg == '0)
                        state_next = S_DONE;
                    else
                    begin
                        sqrt_start = 1'b1;
                        state_next = S_SQRT_WAIT;
                    end
                end
            end
            S_SQRT_WAIT:
            begin
                if (sqrt_done)
                begin
                    sq_next    = sqrt_root;
                    state_next = S_ROOT1;
                end
            end
            S_ROOT1:
            begin
                div_num = {h_abs - sq_reg, 16'd0};
                div_den = {2'b00, a_reg};
                div_wide = 1'b1;
                if (h_reg[63] && h_abs > sq_reg)
                begin
                    div_start  = 1'b1;
                    state_next = S_ROOT1_WAIT;
                end
                else
                    state_next = S_ROOT2;
            end
            S_ROOT1_WAIT:
            begin
                if (div_done)
                begin
                    if (t_q != '0)
                    begin
                        hit_next   = 1'b1;
                        dist_next  = t_q;
                        state_next = S_DONE;
                    end
                    else
                        state_next = S_ROOT2;
                end
            end
            S_ROOT2:
            begin
                div_num = {n2, 16'd0};
                div_den = {2'b00, a_reg};
                div_wide = 1'b1;
                if (n2 != '0)
                begin
                    div_start  = 1'b1;
                    state_next = S_ROOT2_WAIT;
                end
                else
                    state_next = S_DONE;
            end
            S_ROOT2_WAIT:
            begin
                if (div_done)
                begin
                    if (t_q != '0)
                    begin
                        hit_next  = 1'b1;
                        dist_next = t_q;
                    end
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (res_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            step_reg  <= '0;
            acc_reg   <= '0;
            a_reg     <= '0;
            ssum_reg  <= '0;
            h_reg     <= '0;
            sq_reg    <= '0;
            smag_reg  <= '{default: '0};
            dmag_reg  <= '{default: '0};
            sneg_reg  <= '{default: 1'b0};
            dneg_reg  <= '{default: 1'b0};
            hit_reg   <= 1'b0;
            dist_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            step_reg  <= step_next;
            acc_reg   <= acc_next;
            a_reg     <= a_next;
            ssum_reg  <= ssum_next;
            h_reg     <= h_next;
            sq_reg    <= sq_next;
            smag_reg  <= smag_next;
            dmag_reg  <= dmag_next;
            sneg_reg  <= sneg_next;
            dneg_reg  <= dneg_next;
            hit_reg   <= hit_next;
            dist_reg  <= dist_next;
        end
    end

    rnh_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .wide  (div_wide),
        .done  (div_done),
        .quot  (div_quot),
        .sat   (div_sat)
    );

    rnh_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .value (acc_sum),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    assign res_valid  = (state_reg == S_DONE);
    assign res.hit    = hit_reg;
    assign res.t_dist = dist_reg;
    assign busy       = (state_reg != S_IDLE);

endmodule

@@ design/ray_ellipsoid_nearest_hit.sv @@
// Top level: input capture, nearest-hit record of the current set, output register.
// Depends on rnh_pkg, rnh_apb_regs, rnh_core.
//
//   channel   direction  handshake                  beat
//   item      in         item_valid / item_ready    item_t
//   result    out        result_valid / result_ready result_t
//   apb       in/out     psel, penable, pready       paddr, pwdata, prdata
//
// From the accepting edge to the core result, a hit runs six axis divides on the
// shared divider, 17 MAC steps, the square root, and one or two distance divides.
// Most of that time is spent in the divider. A negative discriminant or zero a
// ends after the MAC; a zero radius ends at once. Reset clears the record and set
// counter; registers come up at origin 0, dir +z. A stalled result sits in the
// output register; the next item is taken meanwhile.
module ray_ellipsoid_nearest_hit
    import rnh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  item_t             item,
    output logic              result_valid,
    input  logic              result_ready,
    output result_t           result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    ray_cfg_t   cfg;
    item_t      item_reg;
    logic       start_reg;
    logic       core_valid, core_ready, core_busy;
    core_res_t  core_res;

    logic             best_found_reg;
    logic [31:0]      best_dist_reg;
    logic [9:0]       best_id_reg;
    logic [CNT_W-1:0] count_reg;
    logic             result_valid_reg;
    result_t          result_reg;

    logic        take, new_found, set_end, xfer;
    logic [31:0] new_dist;
    logic [9:0]  new_id;

    rnh_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rnh_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start_reg),
        .item      (item_reg),
        .cfg       (cfg),
        .res_valid (core_valid),
        .res_ready (core_ready),
        .res       (core_res),
        .busy      (core_busy)
    );

    assign item_ready = !core_busy && !start_reg;
    assign core_ready = !result_valid_reg || result_ready;
    assign xfer       = core_valid && core_ready;

    // ties keep the earlier item
    assign take      = core_res.hit && (!best_found_reg || core_res.t_dist < best_dist_reg);
    assign new_found = best_found_reg || take;
    assign new_dist  = take ? core_res.t_dist : best_dist_reg;
    assign new_id    = take ? item_reg.point_id : best_id_reg;
    assign set_end   = item_reg.last_in_set || (count_reg == CNT_W'(MAX_POINTS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg        <= 1'b0;
            best_found_reg   <= 1'b0;
            best_dist_reg    <= DIST_MAX;
            best_id_reg      <= '0;
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            start_reg <= item_valid && item_ready;
            if (xfer)
            begin
                result_valid_reg <= 1'b1;
                if (set_end)
                begin
                    best_found_reg <= 1'b0;
                    best_dist_reg  <= DIST_MAX;
                    best_id_reg    <= '0;
                    count_reg      <= '0;
                end
                else
                begin
                    best_found_reg <= new_found;
                    best_dist_reg  <= new_dist;
                    best_id_reg    <= new_id;
                    count_reg      <= count_reg + CNT_W'(1);
                end
            end
            else if (result_ready)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
            item_reg <= item;
        if (xfer)
        begin
            result_reg.item_hit     <= core_res.hit;
            result_reg.item_dist    <= core_res.hit ? core_res.t_dist : 32'd0;
            result_reg.nearest_hit  <= new_found;
            result_reg.nearest_dist <= new_found ? new_dist : 32'd0;
            result_reg.nearest_id   <= new_found ? new_id : 10'd0;
            result_reg.set_done     <= set_end;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready) |=> !item_ready)
        else $error("item taken while previous beat still in flight");

    a_nearest_not_farther: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.item_hit) |->
            (result.nearest_hit && result.nearest_dist <= result.item_dist))
        else $error("nearest record farther than current hit");

    a_core_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        core_valid |-> (core_busy && !start_reg))
        else $error("core result outside of a busy period");

endmodule
